// ===== rtl/linear_index_to_coordinates_defines.svh =====
// Assertion macros used by the RTL of the index unravel block.
`ifndef LINEAR_INDEX_TO_COORDINATES_DEFINES_SVH
`define LINEAR_INDEX_TO_COORDINATES_DEFINES_SVH
`ifndef SYNTHESIS
`define LIC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LIC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LIC_ASSERT(lbl, clk, rstn, prop, msg)
`define LIC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== rtl/lic_pkg.sv =====
// Types and constants of the index unravel block.
`timescale 1ns / 1ps
package lic_pkg;
    localparam int NUM_DIMS  = 6;
    localparam int DIM_W     = 16;
    localparam int RANK_W    = 3;
    localparam int IN_W      = 32;
    localparam int CFG_IDX_W = 3;
    localparam int BPS       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_RANK       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_4 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_5 = 3'd6;

    localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;
    localparam logic [DIM_W-1:0]  SIZE_ONE   = 16'd1;

    typedef logic [DIM_W-1:0] dim_t;
    typedef logic [NUM_DIMS-1:0][DIM_W-1:0] coord_t;
endpackage

// ===== rtl/linear_index_to_coordinates.sv =====
// Row-major flat index to per-dimension coordinate unravel, pipelined.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_linear_index
//  m_      | out       | m_valid / m_ready    | m_coord_0..5, m_out_of_range
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle in, one per cycle out, while the output is not stalled. Each
// dimension is a restoring divider that retires four quotient bits per stage.
// Reset clears the stage valid bits and the configuration registers (rank 4,
// sizes 1). A stall at the output freezes the whole pipe; s_ready follows
// m_ready or an empty output stage.
`timescale 1ns / 1ps
`include "linear_index_to_coordinates_defines.svh"
module linear_index_to_coordinates #(
    parameter int MAX_RANK   = 6,
    parameter int INDEX_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lic_pkg::DIM_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lic_pkg::IN_W-1:0]            s_linear_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_0,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_1,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_2,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_3,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_4,
    output logic [lic_pkg::DIM_W-1:0]           m_coord_5,
    output logic                                m_out_of_range
);
    localparam int IW  = (INDEX_BITS < lic_pkg::IN_W) ? INDEX_BITS : lic_pkg::IN_W;
    localparam int BPS = lic_pkg::BPS;
    localparam int SPD = (IW + BPS - 1) / BPS;
    localparam int DW  = SPD * BPS;
    localparam int NS  = MAX_RANK * SPD;

    logic [lic_pkg::RANK_W-1:0] rank_reg;
    lic_pkg::dim_t              size_reg [lic_pkg::NUM_DIMS];
    logic [lic_pkg::RANK_W-1:0] rank_eff;
    lic_pkg::dim_t              div_eff  [lic_pkg::NUM_DIMS];

    logic                       adv;
    logic [NS-1:0]              vld_reg;
    logic [NS-1:0]              vld_next;
    lic_pkg::dim_t              rem_reg   [NS];
    lic_pkg::dim_t              rem_next  [NS];
    logic [DW-1:0]              quo_reg   [NS];
    logic [DW-1:0]              quo_next  [NS];
    lic_pkg::coord_t            coord_reg [NS];
    lic_pkg::coord_t            coord_next[NS];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= lic_pkg::RANK_RESET;
            for (int i = 0; i < lic_pkg::NUM_DIMS; i++) begin
                size_reg[i] <= lic_pkg::SIZE_ONE;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lic_pkg::REG_RANK:       rank_reg    <= cfg_data[lic_pkg::RANK_W-1:0];
                lic_pkg::REG_DIM_SIZE_0: size_reg[0] <= cfg_data;
                lic_pkg::REG_DIM_SIZE_1: size_reg[1] <= cfg_data;
                lic_pkg::REG_DIM_SIZE_2: size_reg[2] <= cfg_data;
                lic_pkg::REG_DIM_SIZE_3: size_reg[3] <= cfg_data;
                lic_pkg::REG_DIM_SIZE_4: size_reg[4] <= cfg_data;
                lic_pkg::REG_DIM_SIZE_5: size_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rank_reg == '0) begin
            rank_eff = lic_pkg::RANK_W'(1);
        end else if (rank_reg > lic_pkg::RANK_W'(MAX_RANK)) begin
            rank_eff = lic_pkg::RANK_W'(MAX_RANK);
        end else begin
            rank_eff = rank_reg;
        end
        // unused dimensions and zero sizes divide by one
        for (int d = 0; d < lic_pkg::NUM_DIMS; d++) begin
            if ((lic_pkg::RANK_W'(d) < rank_eff) && (size_reg[d] != '0)) begin
                div_eff[d] = size_reg[d];
            end else begin
                div_eff[d] = lic_pkg::SIZE_ONE;
            end
        end
    end

    // pipeline
    assign adv     = !vld_reg[NS-1] || m_ready;
    assign s_ready = adv;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int  D     = MAX_RANK - 1 - s / SPD;
        localparam bit  FIRST = (s % SPD) == 0;
        localparam bit  LAST  = (s % SPD) == (SPD - 1);

        logic            pv;
        lic_pkg::dim_t   prem;
        logic [DW-1:0]   pquo;
        lic_pkg::coord_t pcoord;

        if (s == 0) begin : g_entry
            assign pv     = s_valid;
            assign prem   = '0;
            assign pquo   = DW'(s_linear_index[IW-1:0]);
            assign pcoord = '0;
        end else begin : g_chain
            assign pv     = vld_reg[s-1];
            assign prem   = rem_reg[s-1];
            assign pquo   = quo_reg[s-1];
            assign pcoord = coord_reg[s-1];
        end

        always_comb begin
            logic [lic_pkg::DIM_W:0]   t;
            logic [lic_pkg::DIM_W-1:0] rem;
            logic [DW-1:0]             quo;
            lic_pkg::coord_t           crd;
            rem = FIRST ? '0 : prem;
            quo = pquo;
            crd = pcoord;
            for (int j = 0; j < BPS; j++) begin
                t   = {rem, quo[DW-1]};
                quo = {quo[DW-2:0], 1'b0};
                if (t >= {1'b0, div_eff[D]}) begin
                    t      = t - {1'b0, div_eff[D]};
                    quo[0] = 1'b1;
                end
                rem = t[lic_pkg::DIM_W-1:0];
            end
            if (LAST) begin
                crd[D] = rem;
            end
            vld_next[s]   = pv;
            rem_next[s]   = rem;
            quo_next[s]   = quo;
            coord_next[s] = crd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            coord_reg <= coord_next;
        end
    end

    assign m_valid        = vld_reg[NS-1];
    assign m_coord_0      = coord_reg[NS-1][0];
    assign m_coord_1      = coord_reg[NS-1][1];
    assign m_coord_2      = coord_reg[NS-1][2];
    assign m_coord_3      = coord_reg[NS-1][3];
    assign m_coord_4      = coord_reg[NS-1][4];
    assign m_coord_5      = coord_reg[NS-1][5];
    assign m_out_of_range = |quo_reg[NS-1];

    `LIC_ASSERT(a_accept_enters, aclk, aresetn, (s_valid && s_ready) |=> vld_reg[0], "accepted beat missing from first stage")
    `LIC_ASSERT(a_stall_holds, aclk, aresetn, !adv |=> (vld_reg == $past(vld_reg)), "pipe moved during stall")
    `LIC_ASSERT(a_no_phantom, aclk, aresetn, (adv && !vld_reg[NS-2]) |=> !m_valid, "result from empty stage")
endmodule
